FILE: src/command_prefix_matcher_unit_macros.svh
// assertion macros for the command prefix matcher
`ifndef COMMAND_PREFIX_MATCHER_UNIT_MACROS_SVH
`define COMMAND_PREFIX_MATCHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/cpm_pkg.sv
`default_nettype none
package cpm_pkg;

  localparam int MAX_COMMANDS_DEF = 64;
  localparam int MAX_LENGTH_DEF   = 32;
  localparam int RESULT_CAP       = 32;
  localparam int CFG_W            = 7;
  localparam int METH_W           = 16;

  localparam logic [2:0] OP_WR_CHAR = 3'd0;
  localparam logic [2:0] OP_WR_LEN  = 3'd1;
  localparam logic [2:0] OP_START   = 3'd2;
  localparam logic [2:0] OP_PUT     = 3'd3;
  localparam logic [2:0] OP_COMPL   = 3'd4;
  localparam logic [2:0] OP_FINISH  = 3'd5;

  localparam logic [2:0] K_ACK    = 3'd0;
  localparam logic [2:0] K_PUT    = 3'd1;
  localparam logic [2:0] K_NOMAT  = 3'd2;
  localparam logic [2:0] K_AMBIG  = 3'd3;
  localparam logic [2:0] K_SUF    = 3'd4;
  localparam logic [2:0] K_EMPTY  = 3'd5;
  localparam logic [2:0] K_FOUND  = 3'd6;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [5:0]        entry;
    logic [4:0]        position;
    logic [7:0]        char_value;
    logic [5:0]        length;
    logic [METH_W-1:0] method_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic              matched;
    logic [6:0]        match_count;
    logic [7:0]        suffix_char;
    logic [METH_W-1:0] found_method;
    logic              last;
  } out_word_t;

endpackage
`default_nettype wire

FILE: src/cpm_ram.sv
`default_nettype none
module cpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/command_prefix_matcher_unit.sv
// channel  | ports                             | handshake
// input    | start, busy, in_word              | taken when start && !busy
// result   | out_strobe, out_word              | one-cycle strobe per word, no stall
// config   | cfg_valid, cfg_ready, cfg_data    | taken when valid && ready
// writes, start, undefined opcodes and queries past the end answer in the cycle after acceptance.
// put runs a binary search over the entries, each probe passing through S_SRCH and S_SEVAL.
// finish searches for the exact length; complete answers from S_CURD or S_LEND.
// a suffix starts after S_CURD, S_LEND and S_SUFR, then streams its bytes through S_SUFR and S_SUFD in turn.
// reset clears control state only; the tables are undefined until written.
// results cannot be stalled, busy holds off new words while one is in work.
`default_nettype none
`include "command_prefix_matcher_unit_macros.svh"
module command_prefix_matcher_unit #(
  parameter int MAX_COMMANDS = cpm_pkg::MAX_COMMANDS_DEF,
  parameter int MAX_LENGTH   = cpm_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire cpm_pkg::in_word_t          in_word,
  output logic                            out_strobe,
  output cpm_pkg::out_word_t              out_word,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [cpm_pkg::CFG_W-1:0]  cfg_data
);
  import cpm_pkg::*;

  localparam int CW  = $clog2(MAX_COMMANDS + 1);
  localparam int IW  = $clog2(MAX_COMMANDS);
  localparam int OW  = $clog2(MAX_LENGTH + 2);
  localparam int LW  = $clog2(MAX_LENGTH + 1);
  localparam int SW  = $clog2(MAX_LENGTH);
  localparam int BD  = MAX_COMMANDS * MAX_LENGTH;
  localparam int AW  = $clog2(BD);
  localparam int LMW = LW + METH_W;
  localparam int NW  = $clog2(RESULT_CAP + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CURD  = 4'd1;
  localparam logic [3:0] S_SRCH  = 4'd2;
  localparam logic [3:0] S_SEVAL = 4'd3;
  localparam logic [3:0] S_DONE  = 4'd4;
  localparam logic [3:0] S_METHD = 4'd5;
  localparam logic [3:0] S_LEND  = 4'd6;
  localparam logic [3:0] S_SUFR  = 4'd7;
  localparam logic [3:0] S_SUFD  = 4'd8;

  localparam logic [1:0] M_MAIN  = 2'd0;
  localparam logic [1:0] M_LOW   = 2'd1;
  localparam logic [1:0] M_HIGH  = 2'd2;
  localparam logic [1:0] M_EXACT = 2'd3;

  logic [3:0]    st_r, st_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, savhi_r, savhi_nxt;
  logic [CW-1:0] mideq_r, mideq_nxt, first_r, first_nxt, pidx_r, pidx_nxt;
  logic [CW-1:0] rind_r, rind_nxt, rlim_r, rlim_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          term_r, term_nxt;
  logic [NW-1:0] n_r, n_nxt, i_r, i_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  out_word_t     out_word_r, out_word_nxt;

  logic            accept;
  logic            b_we;
  logic [AW-1:0]   b_waddr, b_raddr;
  logic [7:0]      b_rdata;
  logic            lm_we;
  logic [IW-1:0]   lm_waddr, lm_raddr;
  logic [LMW-1:0]  lm_wdata, lm_rdata;
  logic            sk_we;
  logic [SW-1:0]   sk_waddr, sk_raddr;
  logic [2*CW-1:0] sk_wdata, sk_rdata;
  logic [LW-1:0]   len_sat, rd_len;
  logic [METH_W-1:0] rd_meth;
  logic [CW-1:0]   cur_ind, cur_lim, mid, p, row;
  logic [AW-1:0]   col;
  logic            wide, need;
  logic            lt, gt, eq;
  logic [OW-1:0]   diff;

  function automatic out_word_t mk(logic [2:0] k, logic m, logic [6:0] c, logic [7:0] s,
                                   logic [METH_W-1:0] f, logic l);
    out_word_t w;
    w.kind = k; w.matched = m; w.match_count = c;
    w.suffix_char = s; w.found_method = f; w.last = l;
    return w;
  endfunction

  assign accept    = start && !busy;
  assign busy      = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // table writes
  assign len_sat = (in_word.length > MAX_LENGTH) ? LW'(MAX_LENGTH) : LW'(in_word.length);
  assign b_we    = accept && (in_word.opcode == OP_WR_CHAR) &&
                   (in_word.entry < MAX_COMMANDS) && (in_word.position < MAX_LENGTH);
  assign b_waddr = AW'(IW'(in_word.entry)) * AW'(MAX_LENGTH) + AW'(in_word.position);
  assign lm_we    = accept && (in_word.opcode == OP_WR_LEN) && (in_word.entry < MAX_COMMANDS);
  assign lm_waddr = IW'(in_word.entry);
  assign lm_wdata = {len_sat, in_word.method_id};
  assign sk_we    = (st_r == S_DONE) && (op_r == OP_PUT);
  assign sk_waddr = SW'(off_r);
  assign sk_wdata = {rind_r, rlim_r};
  assign sk_raddr = SW'(off_r - 1'b1);

  assign rd_len  = lm_rdata[LMW-1:METH_W];
  assign rd_meth = lm_rdata[METH_W-1:0];
  assign cur_ind = (off_r == '0) ? '0 : sk_rdata[2*CW-1:CW];
  assign cur_lim = (off_r == '0) ? cnt_r : sk_rdata[CW-1:0];

  // search probe
  assign wide = (CW+1)'(hi_r) > (CW+1)'(lo_r) + (CW+1)'(1);
  assign need = hi_r > lo_r;
  assign mid  = lo_r + ((hi_r - lo_r) >> 1);
  assign p    = wide ? mid : lo_r;
  assign row  = (st_r == S_SRCH) ? p : rind_r;
  assign col  = (st_r == S_SRCH) ? AW'(off_r) : AW'(off_r) + AW'(i_r);
  assign b_raddr  = AW'(row[IW-1:0]) * AW'(MAX_LENGTH) + col;
  assign lm_raddr = (st_r == S_SRCH) ? p[IW-1:0] :
                    (st_r == S_CURD) ? cur_ind[IW-1:0] : rind_r[IW-1:0];

  assign lt = (pidx_r >= MAX_COMMANDS) || (rd_len <= off_r) || (b_rdata < ch_r);
  assign gt = !lt && (b_rdata > ch_r);
  assign eq = !lt && !gt;
  assign diff = OW'(rd_len) - off_r;

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; ch_nxt = ch_r; off_nxt = off_r; cnt_nxt = cnt_r;
    lo_nxt = lo_r; hi_nxt = hi_r; savhi_nxt = savhi_r; mideq_nxt = mideq_r;
    first_nxt = first_r; pidx_nxt = pidx_r; rind_nxt = rind_r; rlim_nxt = rlim_r;
    mode_nxt = mode_r; term_nxt = term_r; n_nxt = n_r; i_nxt = i_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt = out_word_r;
    if (cfg_valid) begin
      cnt_nxt = (cfg_data > MAX_COMMANDS) ? CW'(MAX_COMMANDS) : CW'(cfg_data);
    end
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_word.opcode;
          ch_nxt = in_word.char_value;
          case (in_word.opcode)
            OP_START: begin
              off_nxt = '0;
              out_strobe_nxt = 1'b1;
              out_word_nxt = mk(K_ACK, 1'b0, '0, '0, '0, 1'b1);
            end
            OP_PUT: begin
              if (off_r >= MAX_LENGTH) begin
                off_nxt = OW'(MAX_LENGTH + 1);
                out_strobe_nxt = 1'b1;
                out_word_nxt = mk(K_PUT, 1'b0, '0, '0, '0, 1'b1);
              end else begin
                st_nxt = S_CURD;
              end
            end
            OP_COMPL, OP_FINISH: begin
              if (off_r > MAX_LENGTH) begin
                out_strobe_nxt = 1'b1;
                out_word_nxt = mk(K_NOMAT, 1'b0, '0, '0, '0, 1'b1);
              end else begin
                st_nxt = S_CURD;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_word_nxt = mk(K_ACK, 1'b0, '0, '0, '0, 1'b1);
            end
          endcase
        end
      end
      S_CURD: begin
        lo_nxt = cur_ind;
        hi_nxt = cur_lim;
        first_nxt = cur_ind;
        rind_nxt = cur_ind;
        case (op_r)
          OP_PUT: begin
            mode_nxt = M_MAIN;
            st_nxt = S_SRCH;
          end
          OP_FINISH: begin
            mode_nxt = M_EXACT;
            if (cur_lim <= cur_ind) begin
              out_strobe_nxt = 1'b1;
              out_word_nxt = mk(K_NOMAT, 1'b0, '0, '0, '0, 1'b1);
              st_nxt = S_IDLE;
            end else begin
              st_nxt = S_SRCH;
            end
          end
          default: begin
            if (cur_lim <= cur_ind || cur_ind >= MAX_COMMANDS) begin
              out_strobe_nxt = 1'b1;
              out_word_nxt = mk(K_NOMAT, 1'b0, '0, '0, '0, 1'b1);
              st_nxt = S_IDLE;
            end else if (cur_lim - cur_ind > CW'(1)) begin
              out_strobe_nxt = 1'b1;
              out_word_nxt = mk(K_AMBIG, 1'b0, 7'(cur_lim - cur_ind), '0, '0, 1'b1);
              st_nxt = S_IDLE;
            end else begin
              st_nxt = S_LEND;
            end
          end
        endcase
      end
      S_LEND: begin
        if (rd_len <= off_r) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt = mk(K_EMPTY, 1'b0, '0, '0, '0, 1'b1);
          st_nxt = S_IDLE;
        end else begin
          n_nxt = (diff > RESULT_CAP) ? NW'(RESULT_CAP) : NW'(diff);
          i_nxt = '0;
          st_nxt = S_SUFR;
        end
      end
      S_SUFR: begin
        st_nxt = S_SUFD;
      end
      S_SUFD: begin
        out_strobe_nxt = 1'b1;
        out_word_nxt = mk(K_SUF, 1'b0, '0, b_rdata, '0, (i_r + 1'b1) == n_r);
        i_nxt = i_r + 1'b1;
        st_nxt = ((i_r + 1'b1) == n_r) ? S_IDLE : S_SUFR;
      end
      S_SRCH: begin
        pidx_nxt = p;
        term_nxt = !wide;
        if (!need) begin
          case (mode_r)
            M_MAIN: begin
              rind_nxt = '0; rlim_nxt = '0; st_nxt = S_DONE;
            end
            M_LOW: begin
              rind_nxt = lo_r; lo_nxt = mideq_r + 1'b1; hi_nxt = savhi_r; mode_nxt = M_HIGH;
            end
            M_HIGH: begin
              rlim_nxt = lo_r; st_nxt = S_DONE;
            end
            default: begin
              rind_nxt = first_r; rlim_nxt = lo_r; st_nxt = S_DONE;
            end
          endcase
        end else begin
          st_nxt = S_SEVAL;
        end
      end
      S_SEVAL: begin
        st_nxt = S_SRCH;
        case (mode_r)
          M_MAIN: begin
            if (term_r) begin
              rind_nxt = eq ? lo_r : '0;
              rlim_nxt = eq ? hi_r : '0;
              st_nxt = S_DONE;
            end else if (lt) begin
              lo_nxt = pidx_r + 1'b1;
            end else if (gt) begin
              hi_nxt = pidx_r;
            end else begin
              savhi_nxt = hi_r; hi_nxt = pidx_r; mideq_nxt = pidx_r; mode_nxt = M_LOW;
            end
          end
          M_LOW: begin
            if (term_r) begin
              rind_nxt = eq ? lo_r : hi_r;
              lo_nxt = mideq_r + 1'b1; hi_nxt = savhi_r; mode_nxt = M_HIGH;
            end else if (lt) begin
              lo_nxt = pidx_r + 1'b1;
            end else begin
              hi_nxt = pidx_r;
            end
          end
          M_HIGH: begin
            if (term_r) begin
              rlim_nxt = eq ? hi_r : lo_r;
              st_nxt = S_DONE;
            end else if (gt) begin
              hi_nxt = pidx_r;
            end else begin
              lo_nxt = pidx_r + 1'b1;
            end
          end
          default: begin
            if (term_r) begin
              rind_nxt = first_r;
              rlim_nxt = (pidx_r < MAX_COMMANDS && rd_len == off_r) ? hi_r : lo_r;
              st_nxt = S_DONE;
            end else if (pidx_r < MAX_COMMANDS && rd_len > off_r) begin
              hi_nxt = pidx_r;
            end else begin
              lo_nxt = pidx_r + 1'b1;
            end
          end
        endcase
      end
      S_DONE: begin
        if (op_r == OP_PUT) begin
          off_nxt = off_r + 1'b1;
          out_strobe_nxt = 1'b1;
          out_word_nxt = mk(K_PUT, rlim_r > rind_r, '0, '0, '0, 1'b1);
          st_nxt = S_IDLE;
        end else if (rlim_r <= rind_r || rind_r >= MAX_COMMANDS) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt = mk(K_NOMAT, 1'b0, '0, '0, '0, 1'b1);
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_METHD;
        end
      end
      S_METHD: begin
        out_strobe_nxt = 1'b1;
        out_word_nxt = mk(K_FOUND, 1'b0, '0, '0, rd_meth, 1'b1);
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      off_r <= '0;
      cnt_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      off_r <= off_nxt;
      cnt_r <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; ch_r <= ch_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    savhi_r <= savhi_nxt; mideq_r <= mideq_nxt; first_r <= first_nxt;
    pidx_r <= pidx_nxt; rind_r <= rind_nxt; rlim_r <= rlim_nxt;
    mode_r <= mode_nxt; term_r <= term_nxt; n_r <= n_nxt; i_r <= i_nxt;
    out_word_r <= out_word_nxt;
  end

  cpm_ram #(.WIDTH(8), .DEPTH(BD)) u_bytes (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_word.char_value),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  cpm_ram #(.WIDTH(LMW), .DEPTH(MAX_COMMANDS)) u_lenmeth (
    .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
    .raddr(lm_raddr), .rdata(lm_rdata)
  );

  cpm_ram #(.WIDTH(2*CW), .DEPTH(MAX_LENGTH)) u_stack (
    .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
    .raddr(sk_raddr), .rdata(sk_rdata)
  );

  `CPM_ASSERT_NXT(a_ack, clk, rst_n, accept && (in_word.opcode == OP_WR_CHAR || in_word.opcode == OP_WR_LEN || in_word.opcode == OP_START), out_strobe && out_word.kind == K_ACK)
  `CPM_ASSERT_IMP(a_last, clk, rst_n, out_strobe && out_word.kind != K_SUF, out_word.last)
  `CPM_ASSERT_IMP(a_off, clk, rst_n, 1'b1, off_r <= OW'(MAX_LENGTH + 1))
endmodule
`default_nettype wire
